// ===== design/plb_pkg.sv =====
// Shared types and constants for the palette line blitter.
`timescale 1ns / 1ps
`default_nettype none

package plb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int PALETTE_DEPTH_DEF = 256;

    localparam int MIXED_X_LO     = 161;
    localparam int MIXED_X_W      = 157;
    localparam int MIXED_HEIGHT   = 220;
    localparam int FULL_HEIGHT    = 240;
    localparam int FIRST_BAND_MAX = 219;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [1:0] {
        ACT_PALETTE = 2'd0,
        ACT_FRAME   = 2'd1,
        ACT_LINE    = 2'd2,
        ACT_PIXEL   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_OFFSET   = 3'd0,
        REG_Y_OFFSET   = 3'd1,
        REG_MIXED      = 3'd2,
        REG_TRANS_ON   = 3'd3,
        REG_TRANS_IDX  = 3'd4,
        REG_BG_IDX     = 3'd5,
        REG_RESTORE_BG = 3'd6
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== design/palette_line_blit_transparent_clip_core.sv =====
// Palette line blitter: color lookup, color keying, window clipping and dirty band tracking.
//
// Input items arrive on the s_ channel (valid/ready) and each one yields exactly one
// result on the m_ channel (valid/ready). An item is a palette write, a frame start,
// a line start or one palette-index pixel. The palette sits in a single-port-write,
// single-port-read synchronous memory; a pixel issues its read at its input transfer
// and the registered read data forms the color of the result.
// The result is shown in the cycle after the input transfer.
// Throughput is one item per cycle, set by the one palette read per pixel.
// The result register frees itself in the same cycle its transfer happens, so s_ready
// stays high while the receiver keeps taking results. When the receiver stalls, the
// result holds and s_ready drops until the result is taken.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata while no item is in
// flight; the user must keep to this; the block does not enforce it. Synchronous active-low
// reset clears the registers, the line origin, the column count and the dirty band
// (220 to -1); the palette holds no defined value until written and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module palette_line_blit_transparent_clip_core #(
    parameter int SCREEN_WIDTH  = plb_pkg::SCREEN_WIDTH_DEF,
    parameter int PALETTE_DEPTH = plb_pkg::PALETTE_DEPTH_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_we,
    input  wire  [plb_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire  [plb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [1:0]                       s_action,
    input  wire  [7:0]                       s_value,
    input  wire  [15:0]                      s_color,
    input  wire  [11:0]                      s_line_x,
    input  wire  [11:0]                      s_line_y,
    input  wire                              s_first_frame,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_write_valid,
    output logic [8:0]                       m_screen_x,
    output logic [7:0]                       m_screen_y,
    output logic [15:0]                      m_pixel_color,
    output logic [7:0]                       m_band_min_y,
    output logic signed [8:0]                m_band_max_y
);

    import plb_pkg::*;

    localparam int CNT_W  = $clog2(SCREEN_WIDTH + 1);
    localparam int COL_W  = ((CNT_W > 12) ? CNT_W : 12) + 2;
    localparam int ROW_W  = 14;
    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int IDX_RECIP = 65536 / PALETTE_DEPTH + 1;

    logic signed [11:0]       x_off_reg;
    logic signed [11:0]       y_off_reg;
    logic                     mixed_reg;
    logic                     trans_on_reg;
    logic [7:0]               trans_idx_reg;
    logic [7:0]               bg_idx_reg;
    logic                     restore_reg;

    logic [11:0]              origin_x_reg, origin_x_next;
    logic [11:0]              row_reg, row_next;
    logic [CNT_W-1:0]         col_cnt_reg, col_cnt_next;
    logic signed [8:0]        band_min_reg, band_min_next;
    logic signed [8:0]        band_max_reg, band_max_next;

    logic                     out_valid_reg;
    logic                     out_wr_reg;
    logic [8:0]               out_x_reg;
    logic [7:0]               out_y_reg;
    logic [15:0]              pal_rdata_reg;

    logic [15:0]              pal_mem [PALETTE_DEPTH];

    action_t                  act;
    logic                     in_xfer;
    logic signed [COL_W-1:0]  col_sum;
    logic signed [COL_W-1:0]  x_lo;
    logic signed [COL_W-1:0]  x_hi;
    logic signed [ROW_W-1:0]  row_sum;
    logic signed [ROW_W-1:0]  y_max;
    logic signed [8:0]        row_band;
    logic                     cnt_ok;
    logic [7:0]               pix_idx;
    logic                     keyed;
    logic                     draw;
    logic [23:0]              idx_prod;
    logic [7:0]               idx_quot;
    logic [8:0]               idx_back;
    logic [7:0]               rem;
    logic [PAL_AW-1:0]        rd_addr;
    logic                     pal_we;

    assign act     = action_t'(s_action);
    assign s_ready = !out_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    assign col_sum = COL_W'(x_off_reg) + $signed(COL_W'(origin_x_reg))
                   + $signed(COL_W'(col_cnt_reg));
    assign row_sum = ROW_W'(y_off_reg) + $signed(ROW_W'(row_reg));
    assign row_band = row_sum[8:0];

    assign x_lo  = mixed_reg ? COL_W'(MIXED_X_LO) : '0;
    assign x_hi  = mixed_reg ? COL_W'(MIXED_X_LO + MIXED_X_W) : COL_W'(SCREEN_WIDTH);
    assign y_max = mixed_reg ? ROW_W'(MIXED_HEIGHT) : ROW_W'(FULL_HEIGHT);

    assign cnt_ok  = col_cnt_reg < CNT_W'(SCREEN_WIDTH);
    assign pix_idx = (restore_reg && s_value == trans_idx_reg) ? bg_idx_reg : s_value;
    assign keyed   = trans_on_reg && !restore_reg && pix_idx == trans_idx_reg;

    assign draw = act == ACT_PIXEL && cnt_ok && !keyed
               && row_sum >= 0 && row_sum < y_max
               && col_sum >= x_lo && col_sum < x_hi;

    // Index reduction modulo the palette depth by reciprocal multiplication.
    assign idx_prod = 24'(pix_idx) * 24'(IDX_RECIP);
    assign idx_quot = idx_prod[23:16];
    assign idx_back = 9'(idx_quot) * 9'(PALETTE_DEPTH);
    assign rem      = pix_idx - idx_back[7:0];

    assign rd_addr = rem[PAL_AW-1:0];
    assign pal_we  = in_xfer && act == ACT_PALETTE && 9'(s_value) < 9'(PALETTE_DEPTH);

    always_comb begin
        origin_x_next = origin_x_reg;
        row_next      = row_reg;
        col_cnt_next  = col_cnt_reg;
        band_min_next = band_min_reg;
        band_max_next = band_max_reg;
        case (act)
            ACT_FRAME: begin
                if (s_first_frame) begin
                    band_min_next = '0;
                    band_max_next = 9'(FIRST_BAND_MAX);
                end else begin
                    band_min_next = 9'(MIXED_HEIGHT);
                    band_max_next = '1;
                end
            end
            ACT_LINE: begin
                origin_x_next = s_line_x;
                row_next      = s_line_y;
                col_cnt_next  = '0;
            end
            ACT_PIXEL: begin
                if (cnt_ok) begin
                    col_cnt_next = col_cnt_reg + CNT_W'(1);
                end
                if (draw && mixed_reg) begin
                    if (row_band < band_min_reg) begin
                        band_min_next = row_band;
                    end
                    if (row_band > band_max_reg) begin
                        band_max_next = row_band;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_off_reg     <= '0;
            y_off_reg     <= '0;
            mixed_reg     <= 1'b0;
            trans_on_reg  <= 1'b0;
            trans_idx_reg <= '0;
            bg_idx_reg    <= '0;
            restore_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_X_OFFSET:   x_off_reg     <= cfg_wdata;
                REG_Y_OFFSET:   y_off_reg     <= cfg_wdata;
                REG_MIXED:      mixed_reg     <= cfg_wdata[0];
                REG_TRANS_ON:   trans_on_reg  <= cfg_wdata[0];
                REG_TRANS_IDX:  trans_idx_reg <= cfg_wdata[7:0];
                REG_BG_IDX:     bg_idx_reg    <= cfg_wdata[7:0];
                REG_RESTORE_BG: restore_reg   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg  <= '0;
            row_reg       <= '0;
            col_cnt_reg   <= '0;
            band_min_reg  <= 9'(MIXED_HEIGHT);
            band_max_reg  <= '1;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                origin_x_reg  <= origin_x_next;
                row_reg       <= row_next;
                col_cnt_reg   <= col_cnt_next;
                band_min_reg  <= band_min_next;
                band_max_reg  <= band_max_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            out_wr_reg <= draw;
            out_x_reg  <= draw ? col_sum[8:0] : '0;
            out_y_reg  <= draw ? row_sum[7:0] : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[s_value[PAL_AW-1:0]] <= s_color;
        end
        if (in_xfer && draw) begin
            pal_rdata_reg <= pal_mem[rd_addr];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_write_valid = out_wr_reg;
    assign m_screen_x    = out_x_reg;
    assign m_screen_y    = out_y_reg;
    assign m_pixel_color = out_wr_reg ? pal_rdata_reg : '0;
    assign m_band_min_y  = band_min_reg[7:0];
    assign m_band_max_y  = band_max_reg;

endmodule

`default_nettype wire

// ===== design/plb_checker.sv =====
// Port-level checks for the palette line blitter and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module plb_checker (
    input wire              aclk,
    input wire              aresetn,
    input wire              m_valid,
    input wire              m_ready,
    input wire              m_write_valid,
    input wire [8:0]        m_screen_x,
    input wire [7:0]        m_screen_y,
    input wire [15:0]       m_pixel_color,
    input wire [7:0]        m_band_min_y,
    input wire signed [8:0] m_band_max_y
);

    import plb_pkg::*;

    // A dropped pixel or a non-pixel item carries no position and no color.
    a_zero_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_valid |->
            m_screen_x == 9'd0 && m_screen_y == 8'd0 && m_pixel_color == 16'd0)
        else $error("result fields nonzero without a pixel write");

    // Written pixels always land on a screen row.
    a_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_valid |-> m_screen_y < 8'(FULL_HEIGHT))
        else $error("written pixel row outside the screen");

    // The dirty band never leaves its empty and full limits.
    a_band_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_band_min_y <= 8'(MIXED_HEIGHT) && m_band_max_y >= -9'sd1
            && m_band_max_y < 9'sd240)
        else $error("dirty band out of range");

    // A stalled result keeps its write flag, color and band maximum through the stall.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_write_valid)
            && $stable(m_pixel_color) && $stable(m_band_max_y))
        else $error("stalled result changed");

endmodule

bind palette_line_blit_transparent_clip_core plb_checker u_plb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_write_valid (m_write_valid),
    .m_screen_x    (m_screen_x),
    .m_screen_y    (m_screen_y),
    .m_pixel_color (m_pixel_color),
    .m_band_min_y  (m_band_min_y),
    .m_band_max_y  (m_band_max_y)
);

`default_nettype wire
